### sv/ovl_pkg.sv
// Shared types, codes and sizes for the ordered value list.
`timescale 1ns / 1ps
`default_nettype none

package ovl_pkg;

    // List geometry.
    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ins_en;
        logic               del_en;
    } cell_cmd_t;

endpackage

`default_nettype wire

### sv/ovl_cell.sv
// One storage cell of the list: holds an entry, compares it and shifts it.
`timescale 1ns / 1ps
`default_nettype none

module ovl_cell (
    input  wire logic                       clk,
    input  wire ovl_pkg::cell_cmd_t         cmd,
    input  wire logic                       occupied,
    input  wire logic                       tail,
    input  wire logic                       hit_in,
    input  wire logic [ovl_pkg::VALUE_W-1:0] next_entry,
    output logic                            hit_out,
    output logic                            first_hit,
    output logic [ovl_pkg::VALUE_W-1:0]     entry
);
    import ovl_pkg::*;

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               match;

    // Compare against the broadcast value; the hit chain keeps the first match.
    always_comb
    begin
        match     = occupied && (entry_reg == cmd.value);
        hit_out   = hit_in || match;
        first_hit = match && !hit_in;
    end

    // Append at the tail, or take the neighbor's entry when a delete closes the gap.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en && tail)
        begin
            entry_next = cmd.value;
        end
        else if (cmd.del_en && hit_out)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### sv/ordered_value_list.sv
// A request transfer is captured in ST_IDLE, and its result is registered at the end of ST_EXEC.
// A new request is not taken until the previous one has finished; the compare-and-shift pass over the cell row
// runs in ST_EXEC, and it waits there while the previous result is not taken.
// Reset: rst_n clears the entry count, the controller state and the result valid flag;
// the entry cells themselves are not reset.
`timescale 1ns / 1ps
`default_nettype none

module ordered_value_list (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ovl_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  wire logic [ovl_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] req_type, [7:2] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ovl_pkg::M_TDATA_W-1:0]      m_tdata,  // [4:0] position, [7:5] zero
    output logic [ovl_pkg::M_TUSER_W-1:0]      m_tuser   // [1:0] status, [7:2] zero
);
    import ovl_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [REQ_W-1:0]    op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STAT_W-1:0]   status_reg;
    logic [STAT_W-1:0]   status_next;
    logic [POS_W-1:0]    position_reg;
    logic [POS_W-1:0]    position_next;

    logic                in_xfer;
    logic                exec;
    logic                advance;
    logic                list_full;
    logic                list_empty;
    logic                any_hit;
    logic [POS_W-1:0]    hit_pos;
    cell_cmd_t           cmd;

    logic [CAPACITY-1:0]             occupied;
    logic [CAPACITY-1:0]             tail;
    logic [CAPACITY:0]               hit_chain;
    logic [CAPACITY-1:0]             first_hit;
    logic [CAPACITY-1:0][VALUE_W-1:0] entry;
    logic [CAPACITY-1:0][VALUE_W-1:0] next_entry;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_tready = 1'b0;
        exec     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EXEC:
            begin
                exec = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
                exec     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_xfer = s_tvalid && s_tready;
    assign advance = exec && (!out_valid_reg || m_tready);

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg    <= s_tuser[REQ_W-1:0];
            value_reg <= s_tdata[VALUE_W-1:0];
        end
    end

    // Per-cell occupancy and tail flags from the entry count.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            occupied[i] = count_reg > COUNT_W'(i);
            tail[i]     = count_reg == COUNT_W'(i);
        end
    end

    assign list_full  = count_reg == COUNT_W'(CAPACITY);
    assign list_empty = count_reg == '0;
    assign any_hit    = hit_chain[CAPACITY];

    // Command to the cell row; enables are only raised in the cycle the result is stored.
    always_comb
    begin
        cmd.value  = value_reg;
        cmd.ins_en = advance && (op_reg == REQ_INSERT) && !list_full;
        cmd.del_en = advance && (op_reg == REQ_DELETE) && any_hit;
    end

    // Row of cells; each passes its hit flag and its entry to its neighbor.
    assign hit_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == CAPACITY - 1)
            begin : g_last
                assign next_entry[g] = '0;
            end
            else
            begin : g_inner
                assign next_entry[g] = entry[g+1];
            end

            ovl_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occupied   (occupied[g]),
                .tail       (tail[g]),
                .hit_in     (hit_chain[g]),
                .next_entry (next_entry[g]),
                .hit_out    (hit_chain[g+1]),
                .first_hit  (first_hit[g]),
                .entry      (entry[g])
            );
        end
    endgenerate

    // Encode the one-hot first match as a 1-based position.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_pos = hit_pos | ({POS_W{first_hit[i]}} & POS_W'(i + 1));
        end
    end

    // Result of the current request.
    always_comb
    begin
        status_next   = STAT_NOT_FOUND;
        position_next = '0;
        case (op_reg)
            REQ_INSERT:
            begin
                status_next = list_full ? STAT_FULL : STAT_DONE;
            end
            REQ_DELETE:
            begin
                if (list_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else if (any_hit)
                begin
                    status_next = STAT_DONE;
                end
            end
            REQ_SEARCH:
            begin
                if (any_hit)
                begin
                    status_next   = STAT_DONE;
                    position_next = hit_pos;
                end
            end
            default:
            begin
                status_next = STAT_NOT_FOUND;
            end
        endcase
    end

    // Entry count follows the inserts and deletes.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.del_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Output register: loaded when a request finishes, freed by a result transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(position_reg);
    assign m_tuser  = M_TUSER_W'(status_reg);

    // An insert that is carried out grows the list by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the entry count");

    // A delete that is carried out shrinks the list by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del_en |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not shrink the entry count");

    // At most one cell claims the first match.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_hit))
        else $error("more than one first match in the cell row");

    // An accepted request is worked on in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> exec && !s_tready)
        else $error("accepted request not taken into execution");

    // Finishing a request always leaves a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("finished request left no result");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the ordered value list: random stream traffic against a predictor.
`timescale 1ns / 1ps

module testbench;

    import ovl_pkg::*;

    // Request code that the block answers as not found.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_AT_REQ   = 400;   // request count that starts the long result hold-off
    localparam int HOLD_CYCLES   = 250;
    localparam int TAIL_ITEMS    = 150;   // no idling once this few requests are left to send
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES  = 8;
    localparam int RAND_PHASES   = 31;
    localparam int PHASE_ITEMS   = 54;

    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic [VALUE_W-1:0] value;
    } list_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
    } list_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Stimulus and scoreboard storage.
    list_req_t pending_reqs[$];
    list_res_t expected_results[$];
    int        total_reqs = 0;
    int        accepted_reqs = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    logic      req_fire = 1'b0;

    // The long result hold-off is taken only once.
    logic      hold_started = 1'b0;

    // Predicted contents of the list.
    logic [VALUE_W-1:0] list_vals [CAPACITY];
    int                 list_len = 0;

    ordered_value_list u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one request to the predicted list and return the result it should give.
    function automatic list_res_t list_apply(input logic [REQ_W-1:0] kind,
                                             input logic [VALUE_W-1:0] value);
        list_res_t res;
        int        hit;
        res.status   = STAT_NOT_FOUND;
        res.position = '0;
        hit = -1;
        for (int i = 0; i < list_len; i++)
        begin
            if (hit < 0 && list_vals[i] == value)
                hit = i;
        end
        case (kind)
            REQ_INSERT:
            begin
                if (list_len >= CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    list_vals[list_len] = value;
                    list_len++;
                    res.status = STAT_DONE;
                end
            end
            REQ_DELETE:
            begin
                if (list_len == 0)
                    res.status = STAT_EMPTY;
                else if (hit >= 0)
                begin
                    // Close the gap left by the removed entry.
                    for (int i = hit; i < list_len - 1; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                    res.status = STAT_DONE;
                end
            end
            REQ_SEARCH:
            begin
                if (hit >= 0)
                begin
                    res.status   = STAT_DONE;
                    res.position = POS_W'(hit + 1);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic void add_req(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] value);
        list_req_t item;
        item.kind  = kind;
        item.value = value;
        pending_reqs.push_back(item);
    endfunction

    // Extremes turn up often so that they collide with each other in the list.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h0000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Build the request sequence: a directed opening, then random phases.
    initial
    begin
        logic [VALUE_W-1:0] pool[8];
        int                 pool_size;
        int                 ins_pct;
        int                 roll;
        logic [VALUE_W-1:0] value;
        logic [REQ_W-1:0]   kind;

        // Empty list: search, delete and an unused code.
        add_req(REQ_SEARCH, 32'h0000_0005);
        add_req(REQ_DELETE, 32'h0000_0005);
        add_req(REQ_UNUSED, 32'hFFFF_FFFF);

        // Fill to capacity with the extremes first and a repeated minus one later on.
        add_req(REQ_INSERT, 32'h8000_0000);
        add_req(REQ_INSERT, 32'h7FFF_FFFF);
        add_req(REQ_INSERT, 32'h0000_0000);
        add_req(REQ_INSERT, 32'hFFFF_FFFF);
        for (int k = 0; k < CAPACITY - 4; k++)
            add_req(REQ_INSERT, (k == 5) ? 32'hFFFF_FFFF : $urandom);
        add_req(REQ_INSERT, 32'h1234_5678);

        // First match with duplicates, delete at the head, misses and the unused code.
        add_req(REQ_SEARCH, 32'h7FFF_FFFF);
        add_req(REQ_SEARCH, 32'hFFFF_FFFF);
        add_req(REQ_DELETE, 32'h8000_0000);
        add_req(REQ_DELETE, 32'h8000_0000);
        add_req(REQ_SEARCH, 32'hFFFF_FFFF);
        add_req(REQ_UNUSED, 32'h0000_0000);
        add_req(REQ_SEARCH, 32'h1234_5678);

        // Each phase draws from a small pool of values so that deletes and searches hit,
        // and leans toward filling or toward draining the list.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            pool_size = $urandom_range(2, 8);
            for (int k = 0; k < 8; k++)
                pool[k] = pick_value();
            ins_pct = (p % 2 == 0) ? $urandom_range(55, 80) : $urandom_range(15, 35);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    kind = REQ_UNUSED;
                else if (roll < 3 + ins_pct)
                    kind = REQ_INSERT;
                else if ($urandom_range(0, 1) == 0)
                    kind = REQ_DELETE;
                else
                    kind = REQ_SEARCH;
                if ($urandom_range(0, 9) == 0)
                    value = $urandom;
                else
                    value = pool[$urandom_range(0, pool_size - 1)];
                add_req(kind, value);
            end
        end
        total_reqs = pending_reqs.size();
    end

    // Reset, then wait for every request to be answered.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (total_reqs == 0 || accepted_reqs < total_reqs || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS ordered_value_list");
        else
            $display("FAIL ordered_value_list");
        $finish;
    end

    // Stop the run when the stream stops moving.
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL ordered_value_list");
        $finish;
    end

    // Request driver: offers queued requests with random bursts of idle cycles.
    always @(negedge clk)
    begin
        int        send_gap;
        list_req_t item;
        if (rst_n)
        begin
            if (!s_tvalid || req_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    item = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.value;
                    s_tuser  <= {{(S_TUSER_W - REQ_W){1'b0}}, item.kind};
                    if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 19);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus one long hold-off that backs up the block.
    always @(negedge clk)
    begin
        int   recv_gap;
        int   hold_left;
        if (rst_n)
        begin
            if (!hold_started && accepted_reqs >= HOLD_AT_REQ)
            begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else if (pending_reqs.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: check each result transfer, then predict from each request transfer.
    always @(posedge clk)
    begin
        list_res_t exp_res;
        req_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d position %0d",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (m_tuser !== {{(M_TUSER_W - STAT_W){1'b0}}, exp_res.status})
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, exp_res.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== {{(M_TDATA_W - POS_W){1'b0}}, exp_res.position})
                    begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, exp_res.position, m_tdata);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(list_apply(s_tuser[REQ_W-1:0], s_tdata));
                accepted_reqs++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

endmodule
